// ----- hdl/tdbd_pkg.sv -----
// Shared types and constants for the temperature deviation bar display.
// Used by the front, queue, back and top level; depends on nothing.
package tdbd_pkg;

  localparam int LED_COUNT_DEF = 16;
  localparam int SAMPLE_W      = 16;
  localparam int IDX_W         = 6;
  localparam int HALF_W        = 6;
  localparam int BYTE_W        = 8;
  localparam int CFG_IDX_W     = 8;
  localparam int OUT_DATA_W    = 32;
  localparam int Q_DEPTH       = 2;

  localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRB_ORDER  = 8'd1;

  localparam logic [7:0]  BRIGHTNESS_RST = 8'd64;
  localparam logic        GRB_ORDER_RST  = 1'b1;
  localparam logic [15:0] TARGET_RST     = 16'h7FFF;
  localparam logic [15:0] HOLD_MARK      = 16'h7FFF;

  localparam logic OP_SAMPLE  = 1'b0;
  localparam logic OP_CAPTURE = 1'b1;

  localparam logic [1:0] KIND_GREEN = 2'd0;
  localparam logic [1:0] KIND_RED   = 2'd1;
  localparam logic [1:0] KIND_BLUE  = 2'd2;

  typedef struct packed {
    logic [1:0]        kind;
    logic [HALF_W-1:0] half;
  } cmd_t;

endpackage

// ----- hdl/tdbd_front.sv -----
// Front end: accepts sample and capture items, keeps the temperature state
// and turns each item that needs a redraw into a frame command. Uses tdbd_pkg.
module tdbd_front import tdbd_pkg::*; #(
  parameter int LED_COUNT = LED_COUNT_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       opcode,
  input  logic signed [SAMPLE_W-1:0] raw_sample,
  output logic                       push,
  output cmd_t                       push_cmd,
  input  logic                       q_full
);

  localparam logic signed [SAMPLE_W:0] HALF_MAX = (SAMPLE_W+1)'(LED_COUNT / 2);

  logic signed [SAMPLE_W-1:0] current_temp;
  logic signed [SAMPLE_W-1:0] target_temp;
  logic signed [SAMPLE_W-1:0] previous_temp;

  logic signed [SAMPLE_W-1:0] t;
  logic signed [SAMPLE_W:0]   diff;
  logic signed [SAMPLE_W:0]   mag;
  logic [HALF_W-1:0]          half;
  logic                       accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign t        = {raw_sample[SAMPLE_W-1], raw_sample[SAMPLE_W-1:1]};
  assign diff     = {t[SAMPLE_W-1], t} - {target_temp[SAMPLE_W-1], target_temp};
  assign mag      = diff[SAMPLE_W] ? -diff : diff;
  assign half     = (mag > HALF_MAX) ? HALF_MAX[HALF_W-1:0] : mag[HALF_W-1:0];

  always_comb begin
    push          = 1'b0;
    push_cmd.kind = KIND_GREEN;
    push_cmd.half = '0;
    if (accept) begin
      if (opcode == OP_CAPTURE) begin
        push = 1'b1;
      end else if (t != previous_temp) begin
        push = 1'b1;
        if (t > target_temp) begin
          push_cmd.kind = KIND_RED;
          push_cmd.half = half;
        end else if (t < target_temp) begin
          push_cmd.kind = KIND_BLUE;
          push_cmd.half = half;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_temp  <= '0;
      target_temp   <= TARGET_RST;
      previous_temp <= '0;
    end else if (accept) begin
      if (opcode == OP_CAPTURE) begin
        target_temp   <= current_temp;
        previous_temp <= HOLD_MARK;
      end else begin
        current_temp  <= t;
        previous_temp <= t;
      end
    end
  end

endmodule

// ----- hdl/tdbd_queue.sv -----
// Short command queue between front and back.
// Holds frame commands of type cmd_t from tdbd_pkg.
module tdbd_queue import tdbd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output cmd_t pop_cmd,
  output logic empty
);

  localparam int PTR_W = $clog2(Q_DEPTH);

  cmd_t             mem [Q_DEPTH];
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;
  logic [PTR_W:0]   count;

  assign full    = (count == (PTR_W+1)'(Q_DEPTH));
  assign empty   = (count == '0);
  assign pop_cmd = mem[rptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push && !full) begin
        wptr <= (wptr == PTR_W'(Q_DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop && !empty) begin
        rptr <= (rptr == PTR_W'(Q_DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      count <= count + (PTR_W+1)'(push && !full) - (PTR_W+1)'(pop && !empty);
    end
  end

endmodule

// ----- hdl/tdbd_back.sv -----
// Back end: draws one LED per cycle, while the output is not stalled, from the
// queued frame command into the output register. Uses tdbd_pkg.
module tdbd_back import tdbd_pkg::*; #(
  parameter int LED_COUNT = LED_COUNT_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_empty,
  input  cmd_t                  q_cmd,
  output logic                  pop,
  input  logic [BYTE_W-1:0]     brightness,
  input  logic                  grb_order,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [OUT_DATA_W-1:0] out_data,
  output logic                  out_last
);

  localparam logic [IDX_W:0]   CENTRE = (IDX_W+1)'(LED_COUNT / 2);
  localparam logic [IDX_W-1:0] LAST   = IDX_W'(LED_COUNT - 1);

  logic              active;
  cmd_t              cmd;
  logic [IDX_W-1:0]  idx;
  logic              advance;
  logic              finish;
  logic              lit;
  logic [IDX_W:0]    idx_x;
  logic [IDX_W:0]    lo;
  logic [IDX_W:0]    hi;
  logic [BYTE_W-1:0] red;
  logic [BYTE_W-1:0] green;
  logic [BYTE_W-1:0] blue;

  assign advance = active && (!out_valid || out_ready);
  assign finish  = advance && (idx == LAST);
  assign pop     = !q_empty && (!active || finish);

  assign idx_x = {1'b0, idx};
  assign lo    = CENTRE - {1'b0, cmd.half};
  assign hi    = CENTRE + {1'b0, cmd.half};

  always_comb begin
    red   = '0;
    green = '0;
    blue  = '0;
    lit   = (idx_x >= lo) && (idx_x < hi);
    unique case (cmd.kind)
      KIND_RED:  red  = lit ? brightness : '0;
      KIND_BLUE: blue = lit ? brightness : '0;
      default:   green = (idx_x == CENTRE - 1'b1 || idx_x == CENTRE) ? brightness : '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        out_valid <= 1'b1;
        idx       <= finish ? '0 : idx + 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (pop) begin
        active <= 1'b1;
      end else if (finish) begin
        active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cmd <= q_cmd;
    end
    if (advance) begin
      out_data <= {2'b00, blue, grb_order ? red : green, grb_order ? green : red, idx};
      out_last <= (idx == LAST);
    end
  end

endmodule

// ----- hdl/temperature_deviation_bar_display.sv -----
// Temperature deviation bar display: front end, command queue, LED drawer.
// A drawing item passes the command queue and the back end's command register before its
// first LED beat is registered. Throughput: one LED beat per cycle unless m_tready stalls;
// a drawing item gives LED_COUNT beats from the back end's LED counter. Items that draw
// nothing take no queue entry. Reset (rst, synchronous): brightness 64, GRB order, target 32767, empty queue.
module temperature_deviation_bar_display import tdbd_pkg::*; #(
  parameter int LED_COUNT = LED_COUNT_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [SAMPLE_W-1:0]   s_tdata,   // raw_sample[15:0]
  input  logic                  s_tuser,   // opcode
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // led_index[5:0], byte0, byte1, byte2, pad[1:0]
  output logic                  m_tlast,   // last_led
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [BYTE_W-1:0]     cfg_data
);

  logic [BYTE_W-1:0] brightness;
  logic              grb_order;
  logic              push;
  cmd_t              push_cmd;
  logic              q_full;
  logic              q_empty;
  logic              pop;
  cmd_t              pop_cmd;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      brightness <= BRIGHTNESS_RST;
      grb_order  <= GRB_ORDER_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_BRIGHTNESS) begin
        brightness <= cfg_data;
      end else if (cfg_index == REG_GRB_ORDER) begin
        grb_order <= cfg_data[0];
      end
    end
  end

  tdbd_front #(.LED_COUNT(LED_COUNT)) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .opcode     (s_tuser),
    .raw_sample (s_tdata),
    .push       (push),
    .push_cmd   (push_cmd),
    .q_full     (q_full)
  );

  tdbd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .empty    (q_empty)
  );

  tdbd_back #(.LED_COUNT(LED_COUNT)) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .q_cmd      (pop_cmd),
    .pop        (pop),
    .brightness (brightness),
    .grb_order  (grb_order),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_data   (m_tdata),
    .out_last   (m_tlast)
  );

endmodule

// ----- hdl/tdbd_checker.sv -----
// Port-level checks for the temperature deviation bar display, bound to the
// top level. Uses tdbd_pkg.
module tdbd_checker import tdbd_pkg::*; #(
  parameter int LED_COUNT = LED_COUNT_DEF
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata,
  input logic                  m_tlast
);

  localparam logic [IDX_W-1:0] LAST = IDX_W'(LED_COUNT - 1);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output beat changed while stalled");

  a_last_index: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tlast == (m_tdata[IDX_W-1:0] == LAST)))
    else $error("tlast does not match final LED index");

  a_frame_runs: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |=> m_tvalid &&
      (m_tdata[IDX_W-1:0] == $past(m_tdata[IDX_W-1:0]) + 1'b1))
    else $error("frame beats not contiguous");

  a_no_mix: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[29:22] != '0) |-> (m_tdata[21:6] == '0))
    else $error("blue lit together with red or green");

endmodule

bind temperature_deviation_bar_display tdbd_checker #(.LED_COUNT(LED_COUNT)) u_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

// ----- verif/tdbd_frame_checker.sv -----
`timescale 1ns / 1ps
// Frame checker for the temperature deviation bar display: watches the item,
// LED and register channels, redraws each frame and compares it beat by beat.
// Depends on tdbd_pkg for widths, register indexes, opcodes and bar kinds.
module tdbd_frame_checker import tdbd_pkg::*; #(
  parameter int LED_COUNT = LED_COUNT_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [SAMPLE_W-1:0]   s_tdata,
  input  logic                  s_tuser,
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [OUT_DATA_W-1:0] m_tdata,
  input  logic                  m_tlast,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [BYTE_W-1:0]     cfg_data,
  output int                    mismatches,
  output int                    pending
);

  typedef struct packed {
    logic [IDX_W-1:0]  led_index;
    logic [BYTE_W-1:0] byte0;
    logic [BYTE_W-1:0] byte1;
    logic [BYTE_W-1:0] byte2;
    logic              last_led;
  } led_beat_t;

  led_beat_t pending_leds[$];

  logic [BYTE_W-1:0]          brightness;
  logic                       grb_order;
  logic signed [SAMPLE_W-1:0] current_temp;
  logic signed [SAMPLE_W-1:0] target_temp;
  logic signed [SAMPLE_W-1:0] previous_temp;

  task automatic draw_frame(input logic [1:0] kind, input int half);
    int centre;
    int i;
    logic [BYTE_W-1:0] red;
    logic [BYTE_W-1:0] green;
    logic [BYTE_W-1:0] blue;
    led_beat_t beat;
    centre = LED_COUNT / 2;
    for (i = 0; i < LED_COUNT; i++) begin
      red = '0;
      green = '0;
      blue = '0;
      if (kind == KIND_GREEN) begin
        if (i == centre - 1 || i == centre) green = brightness;
      end else if (i >= centre - half && i <= centre + half - 1) begin
        if (kind == KIND_RED) red = brightness;
        else blue = brightness;
      end
      beat.led_index = IDX_W'(i);
      beat.byte0 = grb_order ? green : red;
      beat.byte1 = grb_order ? red : green;
      beat.byte2 = blue;
      beat.last_led = (i == LED_COUNT - 1);
      pending_leds.push_back(beat);
    end
  endtask

  task automatic apply_item(input logic op, input logic [SAMPLE_W-1:0] raw);
    logic signed [SAMPLE_W-1:0] halved;
    int diff;
    if (op == OP_CAPTURE) begin
      target_temp = current_temp;
      previous_temp = HOLD_MARK;
      draw_frame(KIND_GREEN, 0);
    end else begin
      halved = $signed(raw) >>> 1;
      current_temp = halved;
      if (halved != previous_temp) begin
        diff = int'(halved) - int'(target_temp);
        if (diff > 0)
          draw_frame(KIND_RED, (diff > LED_COUNT / 2) ? LED_COUNT / 2 : diff);
        else if (diff < 0)
          draw_frame(KIND_BLUE, (-diff > LED_COUNT / 2) ? LED_COUNT / 2 : -diff);
        else
          draw_frame(KIND_GREEN, 0);
      end
      previous_temp = halved;
    end
  endtask

  task automatic check_field(input string name, input logic [7:0] exp, input logic [7:0] act);
    if (act !== exp) begin
      mismatches++;
      $error("%s expected 0x%0h actual 0x%0h", name, exp, act);
    end
  endtask

  task automatic check_beat(input logic [OUT_DATA_W-1:0] data, input logic last);
    led_beat_t exp;
    if (pending_leds.size() == 0) begin
      mismatches++;
      $error("unexpected LED beat: led_index 0x%0h", data[5:0]);
    end else begin
      exp = pending_leds.pop_front();
      check_field("led_index", 8'(exp.led_index), 8'(data[5:0]));
      check_field("byte0", exp.byte0, data[13:6]);
      check_field("byte1", exp.byte1, data[21:14]);
      check_field("byte2", exp.byte2, data[29:22]);
      check_field("last_led", 8'(exp.last_led), 8'(last));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      brightness = BRIGHTNESS_RST;
      grb_order = GRB_ORDER_RST;
      current_temp = '0;
      target_temp = TARGET_RST;
      previous_temp = '0;
      pending_leds.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_BRIGHTNESS: brightness = cfg_data;
          REG_GRB_ORDER: grb_order = cfg_data[0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) apply_item(s_tuser, s_tdata);
      if (m_tvalid && m_tready) check_beat(m_tdata, m_tlast);
    end
    pending = pending_leds.size();
  end

endmodule

// ----- verif/temperature_deviation_bar_display_tb.sv -----
`timescale 1ns / 1ps
// Testbench top for the temperature deviation bar display: clock, reset,
// item and register stimulus, LED back-pressure and the verdict.
// Depends on tdbd_pkg, the block and tdbd_frame_checker.
module temperature_deviation_bar_display_tb;
  import tdbd_pkg::*;

  localparam int LEDS = LED_COUNT_DEF;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [SAMPLE_W-1:0]   s_tdata = '0;
  logic                  s_tuser = OP_SAMPLE;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tlast;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_BRIGHTNESS;
  logic [BYTE_W-1:0]     cfg_data = '0;
  int                    mismatches;
  int                    pending;

  logic                       src_calm = 1'b0;
  logic                       sink_calm = 1'b0;
  logic [SAMPLE_W-1:0]        last_raw = '0;
  logic signed [SAMPLE_W-1:0] last_half = '0;
  int                         target_level = 0;

  always #5 clk = ~clk;

  temperature_deviation_bar_display #(.LED_COUNT(LEDS)) i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  tdbd_frame_checker #(.LED_COUNT(LEDS)) i_frame_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatches(mismatches), .pending(pending)
  );

  task automatic send_item(input logic op, input logic [SAMPLE_W-1:0] raw);
    int gap;
    gap = src_calm ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= raw;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    if (op == OP_CAPTURE) begin
      target_level = int'(last_half);
    end else begin
      last_raw = raw;
      last_half = $signed(raw) >>> 1;
    end
  endtask

  task automatic send_random_item();
    int pick;
    int level;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      send_item(OP_CAPTURE, SAMPLE_W'($urandom));
    end else if (pick < 25) begin
      // same halved value: no frame, unless a capture came since the last sample
      send_item(OP_SAMPLE, {last_raw[SAMPLE_W-1:1], 1'($urandom_range(0, 1))});
    end else if (pick < 40) begin
      send_item(OP_SAMPLE, SAMPLE_W'($urandom));
    end else begin
      level = target_level + $urandom_range(0, 24) - 12;
      if (level > 16383) level = 16383;
      if (level < -16384) level = -16384;
      send_item(OP_SAMPLE, SAMPLE_W'(level * 2 + $urandom_range(0, 1)));
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [BYTE_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    // hold for items still in flight that draw nothing
    repeat (10) @(negedge clk);
  endtask

  initial begin
    int stall;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = sink_calm ? 0 : $urandom_range(0, 15);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      @(negedge clk);
    end
  end

  initial begin
    #5_000_000;
    $display("FAIL temperature_deviation_bar_display");
    $finish;
  end

  initial begin
    logic [BYTE_W-1:0] bright_set[5];
    logic              order_set[5];
    int phase;
    int n;
    bright_set = '{8'd255, 8'd0, 8'd1, 8'd128, 8'd255};
    order_set = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1};
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // target not yet captured: blue bars only
    send_item(OP_SAMPLE, 16'h0000);
    send_item(OP_SAMPLE, 16'h0002);
    send_item(OP_SAMPLE, 16'h8000);
    send_item(OP_SAMPLE, 16'h7FFF);
    send_item(OP_SAMPLE, 16'h7FFE);
    send_item(OP_CAPTURE, 16'h0000);
    send_item(OP_SAMPLE, 16'h7FFF);
    send_item(OP_SAMPLE, 16'hFFFF);
    send_item(OP_CAPTURE, 16'hFFFF);
    send_item(OP_SAMPLE, 16'h0001);
    send_item(OP_SAMPLE, 16'h0003);
    send_item(OP_SAMPLE, 16'hFFFB);
    send_item(OP_SAMPLE, 16'hFFFD);
    send_item(OP_SAMPLE, 16'h000D);
    send_item(OP_SAMPLE, 16'h000F);
    send_item(OP_SAMPLE, 16'h0011);
    send_item(OP_SAMPLE, 16'h7FFE);
    send_item(OP_SAMPLE, 16'h8001);
    send_item(OP_CAPTURE, 16'hAAAA);
    send_item(OP_CAPTURE, 16'h5555);
    send_item(OP_SAMPLE, 16'h8000);
    send_item(OP_SAMPLE, 16'hFFFF);
    drain();

    for (phase = 0; phase < 5; phase++) begin
      if (phase == 3) begin
        write_reg(REG_BRIGHTNESS, BYTE_W'($urandom));
        write_reg(REG_GRB_ORDER, BYTE_W'($urandom_range(0, 1)));
      end else begin
        write_reg(REG_BRIGHTNESS, bright_set[phase]);
        write_reg(REG_GRB_ORDER, {7'd0, order_set[phase]});
      end
      for (n = 0; n < 32; n++) begin
        if (n % 8 == 0) begin
          src_calm = ($urandom_range(0, 3) == 0);
          sink_calm = ($urandom_range(0, 3) == 0);
        end
        send_random_item();
      end
      drain();
    end

    if (mismatches == 0 && pending == 0) begin
      $display("PASS temperature_deviation_bar_display");
    end else begin
      $display("FAIL temperature_deviation_bar_display");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/tdbd_pkg.sv
hdl/tdbd_front.sv
hdl/tdbd_queue.sv
hdl/tdbd_back.sv
hdl/temperature_deviation_bar_display.sv
hdl/tdbd_checker.sv
verif/tdbd_frame_checker.sv
verif/temperature_deviation_bar_display_tb.sv
